/* design/hdtfr_pkg.sv */
// shared types, constants and helpers for the header/trailer frame receiver
// no dependencies; imported by every module of the block
package hdtfr_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned MISS_W  = 16;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned LEN_W   = 7;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned CIDX_W  = 3;

  // longest header and trailer the matcher accepts
  localparam int unsigned HEADER_MAX  = 4;
  localparam int unsigned TRAILER_MAX = 4;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_HEADER_BYTES   = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_HEADER_LEN     = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_PAYLOAD_LEN    = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_TRAILER_ENABLE = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_TRAILER_BYTES  = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_TRAILER_LEN    = 3'd5;

  // result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_DATA   = 1'b1;

  // payload store write request from the sync logic
  typedef struct packed {
    logic              en;
    logic [POS_W-1:0]  pos;
    logic [BYTE_W-1:0] data;
  } store_wr_t;

  // event handed from the sync logic to the readout sequencer
  typedef struct packed {
    logic              valid;
    logic              frame;
    logic [POS_W-1:0]  len;
    logic [MISS_W-1:0] count;
  } sync_evt_t;

  // saturate a length to 1 .. lim
  function automatic logic [LEN_W-1:0] clamp_len(logic [LEN_W-1:0] v, logic [LEN_W-1:0] lim);
    logic [LEN_W-1:0] r;
    if (v == '0) begin
      r = 7'd1;
    end else if (v > lim) begin
      r = lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // expected byte at a position, zero past the fourth byte
  function automatic logic [BYTE_W-1:0] pick_byte(logic [WORD_W-1:0] word, logic [POS_W-1:0] idx);
    logic [BYTE_W-1:0] r;
    r = '0;
    if (idx[POS_W-1:2] == '0) begin
      case (idx[1:0])
        2'd0:    r = word[7:0];
        2'd1:    r = word[15:8];
        2'd2:    r = word[23:16];
        default: r = word[31:24];
      endcase
    end
    return r;
  endfunction

endpackage

/* design/hdtfr_store.sv */
// payload store: single write port, single read port, registered read data
// uses hdtfr_pkg for the byte width
module hdtfr_store
  import hdtfr_pkg::*;
#(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [BYTE_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/hdtfr_sync.sv */
// header/payload/trailer sync logic with configuration registers and miss counter
// uses hdtfr_pkg; drives the payload store write and the readout events
module hdtfr_sync
  import hdtfr_pkg::*;
#(
  parameter int unsigned PAYLOAD_MAX = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0] cfg_data,
  input  logic              accept,
  input  logic [BYTE_W-1:0] rx_byte,
  input  logic              evt_take,
  output store_wr_t         wr,
  output sync_evt_t         evt
);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_TRAILER = 2'd2
  } phase_t;

  localparam logic [LEN_W-1:0] HL_LIM = LEN_W'(HEADER_MAX);
  localparam logic [LEN_W-1:0] TL_LIM = LEN_W'(TRAILER_MAX);
  localparam logic [LEN_W-1:0] PL_LIM = LEN_W'(PAYLOAD_MAX);

  logic [WORD_W-1:0] header_bytes;
  logic [2:0]        header_len;
  logic [4:0]        payload_len;
  logic              trailer_enable;
  logic [WORD_W-1:0] trailer_bytes;
  logic [2:0]        trailer_len;

  phase_t            phase, phase_next;
  logic [POS_W-1:0]  position, position_next;
  logic [MISS_W-1:0] miss, miss_next;
  sync_evt_t         evt_next;

  logic [LEN_W-1:0]  pos1;
  logic [LEN_W-1:0]  hl_n, tl_n, pl_n;
  logic              do_miss, do_frame;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      header_bytes   <= '0;
      header_len     <= 3'd1;
      payload_len    <= 5'd1;
      trailer_enable <= 1'b0;
      trailer_bytes  <= '0;
      trailer_len    <= 3'd1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_HEADER_BYTES:   header_bytes   <= cfg_data;
        CFG_HEADER_LEN:     header_len     <= cfg_data[2:0];
        CFG_PAYLOAD_LEN:    payload_len    <= cfg_data[4:0];
        CFG_TRAILER_ENABLE: trailer_enable <= cfg_data[0];
        CFG_TRAILER_BYTES:  trailer_bytes  <= cfg_data;
        CFG_TRAILER_LEN:    trailer_len    <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // saturated lengths
  assign hl_n = clamp_len({4'd0, header_len}, HL_LIM);
  assign tl_n = clamp_len({4'd0, trailer_len}, TL_LIM);
  assign pl_n = clamp_len({2'd0, payload_len}, PL_LIM);
  assign pos1 = {2'd0, position} + 7'd1;

  // next state for one received byte
  always_comb begin
    phase_next    = phase;
    position_next = position;
    miss_next     = miss;
    evt_next      = evt;
    wr            = '0;
    do_miss       = 1'b0;
    do_frame      = 1'b0;
    if (evt_take) begin
      evt_next.valid = 1'b0;
    end
    if (accept) begin
      unique case (phase)
        PH_PAYLOAD: begin
          wr.en   = ({2'd0, position} < PL_LIM);
          wr.pos  = position;
          wr.data = rx_byte;
          if (pos1 >= pl_n) begin
            position_next = '0;
            if (trailer_enable) begin
              phase_next = PH_TRAILER;
            end else begin
              do_frame = 1'b1;
            end
          end else begin
            position_next = pos1[POS_W-1:0];
          end
        end
        PH_TRAILER: begin
          if (rx_byte != pick_byte(trailer_bytes, position)) begin
            do_miss = 1'b1;
          end else if (pos1 >= tl_n) begin
            do_frame = 1'b1;
          end else begin
            position_next = pos1[POS_W-1:0];
          end
        end
        default: begin
          phase_next = PH_HEADER;
          if (rx_byte != pick_byte(header_bytes, position)) begin
            do_miss = 1'b1;
          end else if (pos1 >= hl_n) begin
            phase_next    = PH_PAYLOAD;
            position_next = '0;
          end else begin
            position_next = pos1[POS_W-1:0];
          end
        end
      endcase
      // mismatch: restart the hunt and report the counter
      if (do_miss) begin
        phase_next     = PH_HEADER;
        position_next  = '0;
        miss_next      = miss + 16'd1;
        evt_next.valid = 1'b1;
        evt_next.frame = 1'b0;
        evt_next.len   = '0;
        evt_next.count = miss + 16'd1;
      end
      // frame complete: clear the counter and start readout
      if (do_frame) begin
        phase_next     = PH_HEADER;
        position_next  = '0;
        miss_next      = '0;
        evt_next.valid = 1'b1;
        evt_next.frame = 1'b1;
        evt_next.len   = pl_n[POS_W-1:0];
        evt_next.count = '0;
      end
    end
  end

  // state and event register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_HEADER;
      position <= '0;
      miss     <= '0;
      evt      <= '0;
    end else begin
      phase    <= phase_next;
      position <= position_next;
      miss     <= miss_next;
      evt      <= evt_next;
    end
  end

endmodule

/* design/hdtfr_seq.sv */
// readout sequencer: streams stored payload bytes or a status word into the output register
// uses hdtfr_pkg; reads the payload store through its registered read port
module hdtfr_seq
  import hdtfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  sync_evt_t         evt,
  output logic              evt_take,
  output logic              busy,
  output logic              rd_en,
  output logic [POS_W-1:0]  rd_pos,
  input  logic [BYTE_W-1:0] rd_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              kind,
  output logic [BYTE_W-1:0] payload_byte,
  output logic [IDX_W-1:0]  byte_index,
  output logic              last,
  output logic [MISS_W-1:0] mismatch_count
);

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } seq_state_t;

  seq_state_t        state, state_next;
  logic [POS_W-1:0]  rd_k, rd_k_next;
  logic [POS_W-1:0]  len, len_next;
  logic              rdata_valid, rdata_valid_next;
  logic [POS_W-1:0]  rdata_k, rdata_k_next;
  logic              rdata_last, rdata_last_next;

  logic              out_valid_next, kind_next, last_next;
  logic [BYTE_W-1:0] payload_byte_next;
  logic [IDX_W-1:0]  byte_index_next;
  logic [MISS_W-1:0] mismatch_count_next;

  logic              out_free, load_data, load_status, issue, issue_last;

  // handshake between read data stage and output register
  assign out_free    = !out_valid || !out_stall;
  assign load_data   = rdata_valid && out_free;
  assign load_status = (state == S_IDLE) && evt.valid && !evt.frame && out_free
                       && !rdata_valid;
  assign issue       = (state == S_READ) && (!rdata_valid || load_data);
  assign issue_last  = ({1'b0, rd_k} + 6'd1) == {1'b0, len};
  assign evt_take    = (state == S_IDLE) && evt.valid && (evt.frame || load_status);
  assign busy        = (state != S_IDLE) || rdata_valid;
  assign rd_en       = issue;
  assign rd_pos      = rd_k;

  // next values
  always_comb begin
    state_next          = state;
    rd_k_next           = rd_k;
    len_next            = len;
    rdata_valid_next    = rdata_valid;
    rdata_k_next        = rdata_k;
    rdata_last_next     = rdata_last;
    out_valid_next      = out_valid;
    kind_next           = kind;
    payload_byte_next   = payload_byte;
    byte_index_next     = byte_index;
    last_next           = last;
    mismatch_count_next = mismatch_count;

    // start of a frame readout
    if ((state == S_IDLE) && evt.valid && evt.frame) begin
      state_next = S_READ;
      rd_k_next  = '0;
      len_next   = evt.len;
    end

    // one store read per cycle while the data stage drains
    if (issue) begin
      rdata_valid_next = 1'b1;
      rdata_k_next     = rd_k;
      rdata_last_next  = issue_last;
      rd_k_next        = rd_k + 5'd1;
      if (issue_last) begin
        state_next = S_IDLE;
      end
    end else if (load_data) begin
      rdata_valid_next = 1'b0;
    end

    // output register
    if (load_data) begin
      out_valid_next      = 1'b1;
      kind_next           = KIND_DATA;
      payload_byte_next   = rd_data;
      byte_index_next     = rdata_k[IDX_W-1:0];
      last_next           = rdata_last;
      mismatch_count_next = '0;
    end else if (load_status) begin
      out_valid_next      = 1'b1;
      kind_next           = KIND_STATUS;
      payload_byte_next   = '0;
      byte_index_next     = '0;
      last_next           = 1'b1;
      mismatch_count_next = evt.count;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rd_k        <= '0;
      len         <= '0;
      rdata_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      rd_k        <= rd_k_next;
      len         <= len_next;
      rdata_valid <= rdata_valid_next;
      out_valid   <= out_valid_next;
    end
    rdata_k        <= rdata_k_next;
    rdata_last     <= rdata_last_next;
    kind           <= kind_next;
    payload_byte   <= payload_byte_next;
    byte_index     <= byte_index_next;
    last           <= last_next;
    mismatch_count <= mismatch_count_next;
  end

endmodule

/* design/header_trailer_frame_receiver_core.sv */
// Fixed-length frame receiver with header sync and optional trailer check.
// Input channel: one received byte per request (rx_byte, in_valid/in_stall).
// The block hunts for the configured header, stores payload_len bytes, then
// matches the trailer when enabled. A wrong header or trailer byte is dropped,
// bumps the 16-bit miss counter and yields one status result (kind 0).
// A good frame yields its payload bytes in order (kind 1), last on the final one.
// Output channel: kind, payload_byte, byte_index, last, mismatch_count with
// out_valid/out_stall, held in an output register.
// A status result passes through the sync event register and then the output register.
// A frame's bytes pass through the sync event register, the sequencer state, the
// payload store's read port and the output register, one byte per cycle while the
// output is not stalled; in_stall is high during the readout. While the last
// result waits in the output register the next byte is already accepted.
// A stalled receiver holds the output register and the store reads wait.
// Reset: registers return to their reset values, the hunt starts at the first
// header byte and the miss counter clears; store contents are undefined.
// Configuration writes go through cfg_write/cfg_index/cfg_data; the user must
// issue them only while idle, as the block itself does not enforce this.
module header_trailer_frame_receiver_core
  import hdtfr_pkg::*;
#(
  parameter int unsigned PAYLOAD_MAX = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] rx_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              kind,
  output logic [BYTE_W-1:0] payload_byte,
  output logic [IDX_W-1:0]  byte_index,
  output logic              last,
  output logic [MISS_W-1:0] mismatch_count
);

  localparam int unsigned ADDR_W = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;

  store_wr_t         wr;
  sync_evt_t         evt;
  logic              evt_take, busy, accept;
  logic              rd_en;
  logic [POS_W-1:0]  rd_pos;
  logic [BYTE_W-1:0] rd_data;
  logic [POS_W:0]    wr_pos_ext, rd_pos_ext;

  // input handshake: hold off while an event or readout is in flight
  assign in_stall = evt.valid || busy;
  assign accept   = in_valid && !in_stall;

  // store addresses from positions
  assign wr_pos_ext = {1'b0, wr.pos};
  assign rd_pos_ext = {1'b0, rd_pos};

  hdtfr_sync #(
    .PAYLOAD_MAX (PAYLOAD_MAX)
  ) u_sync (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .rx_byte   (rx_byte),
    .evt_take  (evt_take),
    .wr        (wr),
    .evt       (evt)
  );

  hdtfr_store #(
    .DEPTH  (PAYLOAD_MAX),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr.en),
    .wr_addr (wr_pos_ext[ADDR_W-1:0]),
    .wr_data (wr.data),
    .rd_en   (rd_en),
    .rd_addr (rd_pos_ext[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  hdtfr_seq u_seq (
    .clk            (clk),
    .rst            (rst),
    .evt            (evt),
    .evt_take       (evt_take),
    .busy           (busy),
    .rd_en          (rd_en),
    .rd_pos         (rd_pos),
    .rd_data        (rd_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .payload_byte   (payload_byte),
    .byte_index     (byte_index),
    .last           (last),
    .mismatch_count (mismatch_count)
  );

endmodule
